/* sv/ddr_pkg.sv */
// Types and constants for the direction deflection rotation block.
// Word layouts, pipeline stage records and the CORDIC angle table.
// No dependencies.
package ddr_pkg;

   localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
   localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
   localparam logic signed [32:0] PI_Q29 = 33'sd1686629713;
   localparam logic signed [32:0] HALF_PI_Q29 = 33'sd843314857;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   typedef struct packed {
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic signed [31:0] cos_polar;
      logic signed [31:0] deflect_azimuth;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic signed [31:0] new_z;
      logic passed_through;
   } rsp_type;

   // fields that ride along the whole pipe
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic c_neg;
      logic pass;
   } carry_type;

   typedef struct packed {
      logic [63:0] v;
      logic [63:0] res;
   } sqrt_type;

   typedef struct packed {
      logic [61:0] rem;
      logic [31:0] den;
      logic [30:0] quo;
      logic neg;
      logic zero;
   } div_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [32:0] z;
      logic flip;
   } cordic_type;

   typedef struct packed {
      logic signed [33:0] tx;
      logic signed [33:0] ty;
      logic signed [31:0] exx;
      logic signed [31:0] exy;
      logic signed [31:0] sinth;
      logic signed [31:0] cosph;
      logic signed [31:0] sinph;
   } geo_type;

   // round(atan(2^-i) * 2^29)
   function automatic logic signed [32:0] atan_stage(input int i);
      logic signed [32:0] v;
      case (i)
         0: v = 33'sd421657428;
         1: v = 33'sd248918915;
         2: v = 33'sd131521918;
         3: v = 33'sd66762579;
         4: v = 33'sd33510843;
         5: v = 33'sd16771758;
         6: v = 33'sd8387925;
         7: v = 33'sd4194219;
         8: v = 33'sd2097141;
         9: v = 33'sd1048575;
         10: v = 33'sd524288;
         default: v = (i < 30) ? (33'sd1 <<< (29 - i)) : 33'sd0;
      endcase
      return v;
   endfunction

endpackage

/* sv/direction_deflection_rotation.sv */
// Direction deflection rotation, fully pipelined top level.
// Depends on ddr_pkg (word types, stage records, CORDIC table).
//
// Use: drive req_word and raise start; the word is taken at any rising edge
// with start high and busy low. busy is low except while reset is high, so a
// new word may enter on every cycle (one word per clock sustained).
// Each result shows on rsp_word for one cycle with rsp_strobe high; there is
// no back pressure on the result side and the receiver must take it then.
// The depth does not depend on CORDIC_STAGES. It is set by the chain
// squares -> 32-step square root -> 31-step restoring dividers -> products
// -> second 32-step square root -> final products and sums -> saturation.
// The CORDIC (cos/sin of the azimuth) runs beside the root and divide stages.
// Results come out in acceptance order. Synchronous reset clears all valid
// bits, so words in flight are dropped; data registers are not reset.
module direction_deflection_rotation #(
   parameter int CORDIC_STAGES = 30
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ddr_pkg::req_type req_word,
   output logic             rsp_strobe,
   output ddr_pkg::rsp_type rsp_word
);

   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS = 31;
   localparam int T_SUM = 2;
   localparam int T_RT = T_SUM + SQRT_STEPS;
   localparam int T_DVF = T_RT + DIV_STEPS + 2;
   localparam int T_DV = T_DVF - 1;
   localparam int T_P2 = T_DVF + 2;
   localparam int T_TZ = T_P2 + 1 + SQRT_STEPS;
   localparam int T_F2 = T_TZ + 2;
   localparam int T_OUT = T_F2 + 1;
   localparam int T_CR = CORDIC_STAGES + 1;
   localparam int CR_DLY = T_DVF - T_CR;
   localparam int SP_DLY = T_DVF - T_RT;
   localparam int GEO_LEN = T_TZ - T_P2 + 1;
   localparam int DIV_UNITS = 4;
   localparam int U_COSPH = 0;
   localparam int U_SINPH = 1;
   localparam int U_COSTH = 2;
   localparam int U_SINTH = 3;

   logic                 vld_ff [0:T_F2];
   ddr_pkg::carry_type   cr_ff [0:T_F2];
   ddr_pkg::carry_type   cr_in;
   logic signed [31:0]   in_c_ff;
   logic signed [31:0]   in_a_ff;

   logic signed [63:0]   xx_in, yy_in, zz_in, cc_in;
   logic [62:0]          xx_ff, yy_ff, zz_ff, cc_ff;
   logic [63:0]          rho2_ff, r2_ff, remc_ff;

   ddr_pkg::sqrt_type    rho_sq_ff [0:SQRT_STEPS-1];
   ddr_pkg::sqrt_type    r_sq_ff [0:SQRT_STEPS-1];
   ddr_pkg::sqrt_type    sp_sq_ff [0:SQRT_STEPS-1];
   ddr_pkg::sqrt_type    tz_sq_ff [0:SQRT_STEPS-1];
   logic [31:0]          rho_in, r_in;

   ddr_pkg::div_type     dv_ff [0:DIV_UNITS-1][0:DIV_STEPS];
   logic signed [31:0]   q_ff [0:DIV_UNITS-1];
   logic [31:0]          sp_dly_ff [0:SP_DLY-1];

   ddr_pkg::cordic_type  cd_ff [0:CORDIC_STAGES];
   ddr_pkg::cordic_type  fold_in;
   logic signed [32:0]   az_in;
   logic signed [33:0]   ca_dly_ff [0:CR_DLY-1];
   logic signed [33:0]   sa_dly_ff [0:CR_DLY-1];

   logic signed [66:0]   ptx_ff, pty_ff;
   logic signed [63:0]   pex_ff, pey_ff;
   logic signed [31:0]   p1_cosph_ff, p1_sinph_ff, p1_sinth_ff;
   logic signed [33:0]   tx_in, ty_in;
   logic signed [67:0]   txx_in, tyy_in;
   logic [63:0]          txx_ff, tyy_ff;
   ddr_pkg::geo_type     geo_ff [0:GEO_LEN-1];
   logic signed [65:0]   tzrem_in;
   logic [63:0]          tz_seed_ff;

   ddr_pkg::geo_type     gf;
   ddr_pkg::carry_type   cf;
   logic signed [32:0]   tzs_in, exz_in;
   logic signed [67:0]   px0_ff, px1_ff, px2_ff, py0_ff, py1_ff, py2_ff, pz0_ff, pz1_ff;
   logic signed [67:0]   sx_ff, sy_ff, sz_ff;

   logic                 rsp_strobe_ff;
   ddr_pkg::rsp_type     rsp_word_ff;

   function automatic ddr_pkg::sqrt_type sqrt_step(input ddr_pkg::sqrt_type s, input int k);
      logic [63:0] bitv;
      logic [63:0] trial;
      ddr_pkg::sqrt_type o;
      bitv = 64'd1 << (62 - 2 * k);
      trial = s.res + bitv;
      o.v = s.v;
      o.res = s.res >> 1;
      if (s.v >= trial) begin
         o.v = s.v - trial;
         o.res = (s.res >> 1) + bitv;
      end
      return o;
   endfunction

   function automatic ddr_pkg::div_type div_init(input logic signed [32:0] num,
                                                 input logic [31:0] den);
      logic [32:0] mag;
      ddr_pkg::div_type o;
      mag = num[32] ? -num : num;
      o.rem = {mag[31:0], 30'd0};
      o.den = den;
      o.quo = '0;
      o.neg = num[32];
      o.zero = (den == 32'd0);
      return o;
   endfunction

   // restoring step, quotient bit DIV_STEPS-1-j
   function automatic ddr_pkg::div_type div_step(input ddr_pkg::div_type d, input int j);
      logic [61:0] sh;
      ddr_pkg::div_type o;
      sh = 62'(d.den) << (DIV_STEPS - 1 - j);
      o = d;
      if (d.rem >= sh) begin
         o.rem = d.rem - sh;
         o.quo = d.quo | (31'd1 << (DIV_STEPS - 1 - j));
      end
      return o;
   endfunction

   function automatic logic signed [31:0] div_final(input ddr_pkg::div_type d,
                                                    input logic signed [31:0] dflt);
      logic signed [31:0] q;
      q = $signed({1'b0, d.quo});
      if (d.zero) begin
         return dflt;
      end
      return d.neg ? -q : q;
   endfunction

   function automatic ddr_pkg::cordic_type cordic_step(input ddr_pkg::cordic_type c,
                                                       input int i);
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [32:0] at;
      ddr_pkg::cordic_type o;
      dx = c.y >>> i;
      dy = c.x >>> i;
      at = ddr_pkg::atan_stage(i);
      o = c;
      if (!c.z[32]) begin
         o.x = c.x - dx;
         o.y = c.y + dy;
         o.z = c.z - at;
      end else begin
         o.x = c.x + dx;
         o.y = c.y - dy;
         o.z = c.z + at;
      end
      return o;
   endfunction

   function automatic logic signed [31:0] sat_q30(input logic signed [67:0] s);
      logic signed [37:0] t;
      t = 38'(s >>> 30);
      if (t > 38'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end
      if (t < -38'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return t[31:0];
   endfunction

   assign busy = reset;

   always_comb begin
      cr_in.x = req_word.dir_x;
      cr_in.y = req_word.dir_y;
      cr_in.z = req_word.dir_z;
      cr_in.c_neg = req_word.cos_polar[31];
      cr_in.pass = (req_word.cos_polar == ddr_pkg::ONE_Q30) &&
                   (req_word.deflect_azimuth == 32'sd0);
   end

   always_comb begin
      xx_in = 64'(cr_ff[0].x) * 64'(cr_ff[0].x);
      yy_in = 64'(cr_ff[0].y) * 64'(cr_ff[0].y);
      zz_in = 64'(cr_ff[0].z) * 64'(cr_ff[0].z);
      cc_in = 64'(in_c_ff) * 64'(in_c_ff);
      rho_in = rho_sq_ff[SQRT_STEPS-1].res[31:0];
      r_in = r_sq_ff[SQRT_STEPS-1].res[31:0];
   end

   // fold the azimuth into [-pi/2, pi/2]
   always_comb begin
      az_in = 33'(in_a_ff);
      fold_in.x = ddr_pkg::CORDIC_GAIN_Q30;
      fold_in.y = 34'sd0;
      fold_in.z = az_in;
      fold_in.flip = 1'b0;
      if (az_in > ddr_pkg::HALF_PI_Q29) begin
         fold_in.z = az_in - ddr_pkg::PI_Q29;
         fold_in.flip = 1'b1;
      end else if (az_in < -ddr_pkg::HALF_PI_Q29) begin
         fold_in.z = az_in + ddr_pkg::PI_Q29;
         fold_in.flip = 1'b1;
      end
   end

   always_comb begin
      tx_in = 34'(ptx_ff >>> 30);
      ty_in = 34'(pty_ff >>> 30);
      txx_in = 68'(tx_in) * 68'(tx_in);
      tyy_in = 68'(ty_in) * 68'(ty_in);
      tzrem_in = $signed({2'b00, ddr_pkg::ONE_Q60}) - $signed({2'b00, txx_ff})
                 - $signed({2'b00, tyy_ff});
      gf = geo_ff[GEO_LEN-1];
      cf = cr_ff[T_TZ];
      tzs_in = cf.c_neg ? -$signed({1'b0, tz_sq_ff[SQRT_STEPS-1].res[31:0]})
                        : $signed({1'b0, tz_sq_ff[SQRT_STEPS-1].res[31:0]});
      exz_in = -33'(gf.sinth);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t <= T_F2; t++) begin
            vld_ff[t] <= 1'b0;
         end
         rsp_strobe_ff <= 1'b0;
      end else begin
         vld_ff[0] <= start & ~busy;
         for (int t = 1; t <= T_F2; t++) begin
            vld_ff[t] <= vld_ff[t-1];
         end
         rsp_strobe_ff <= vld_ff[T_F2];
      end
   end

   always_ff @(posedge clock) begin
      // input and carry line
      cr_ff[0] <= cr_in;
      for (int t = 1; t <= T_F2; t++) begin
         cr_ff[t] <= cr_ff[t-1];
      end
      in_c_ff <= req_word.cos_polar;
      in_a_ff <= req_word.deflect_azimuth;

      // squares, then sums and 1 - c^2 clamped
      xx_ff <= xx_in[62:0];
      yy_ff <= yy_in[62:0];
      zz_ff <= zz_in[62:0];
      cc_ff <= cc_in[62:0];
      rho2_ff <= 64'(xx_ff) + 64'(yy_ff);
      r2_ff <= 64'(xx_ff) + 64'(yy_ff) + 64'(zz_ff);
      remc_ff <= (64'(cc_ff) < ddr_pkg::ONE_Q60) ? ddr_pkg::ONE_Q60 - 64'(cc_ff) : 64'd0;

      // square roots: one result bit per stage
      rho_sq_ff[0] <= sqrt_step(ddr_pkg::sqrt_type'{v: rho2_ff, res: 64'd0}, 0);
      r_sq_ff[0] <= sqrt_step(ddr_pkg::sqrt_type'{v: r2_ff, res: 64'd0}, 0);
      sp_sq_ff[0] <= sqrt_step(ddr_pkg::sqrt_type'{v: remc_ff, res: 64'd0}, 0);
      tz_sq_ff[0] <= sqrt_step(ddr_pkg::sqrt_type'{v: tz_seed_ff, res: 64'd0}, 0);
      for (int k = 1; k < SQRT_STEPS; k++) begin
         rho_sq_ff[k] <= sqrt_step(rho_sq_ff[k-1], k);
         r_sq_ff[k] <= sqrt_step(r_sq_ff[k-1], k);
         sp_sq_ff[k] <= sqrt_step(sp_sq_ff[k-1], k);
         tz_sq_ff[k] <= sqrt_step(tz_sq_ff[k-1], k);
      end

      // dividers: x/rho, y/rho, z/r, rho/r
      dv_ff[U_COSPH][0] <= div_init(33'(cr_ff[T_RT].x), rho_in);
      dv_ff[U_SINPH][0] <= div_init(33'(cr_ff[T_RT].y), rho_in);
      dv_ff[U_COSTH][0] <= div_init(33'(cr_ff[T_RT].z), r_in);
      dv_ff[U_SINTH][0] <= div_init($signed({1'b0, rho_in}), r_in);
      for (int u = 0; u < DIV_UNITS; u++) begin
         for (int j = 0; j < DIV_STEPS; j++) begin
            dv_ff[u][j+1] <= div_step(dv_ff[u][j], j);
         end
      end
      q_ff[U_COSPH] <= div_final(dv_ff[U_COSPH][DIV_STEPS], ddr_pkg::ONE_Q30);
      q_ff[U_SINPH] <= div_final(dv_ff[U_SINPH][DIV_STEPS], 32'sd0);
      q_ff[U_COSTH] <= div_final(dv_ff[U_COSTH][DIV_STEPS], ddr_pkg::ONE_Q30);
      q_ff[U_SINTH] <= div_final(dv_ff[U_SINTH][DIV_STEPS], 32'sd0);

      sp_dly_ff[0] <= sp_sq_ff[SQRT_STEPS-1].res[31:0];
      for (int t = 1; t < SP_DLY; t++) begin
         sp_dly_ff[t] <= sp_dly_ff[t-1];
      end

      // CORDIC, then delay to meet the dividers
      cd_ff[0] <= fold_in;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         cd_ff[i+1] <= cordic_step(cd_ff[i], i);
      end
      ca_dly_ff[0] <= cd_ff[CORDIC_STAGES].flip ? -cd_ff[CORDIC_STAGES].x
                                                 : cd_ff[CORDIC_STAGES].x;
      sa_dly_ff[0] <= cd_ff[CORDIC_STAGES].flip ? -cd_ff[CORDIC_STAGES].y
                                                 : cd_ff[CORDIC_STAGES].y;
      for (int t = 1; t < CR_DLY; t++) begin
         ca_dly_ff[t] <= ca_dly_ff[t-1];
         sa_dly_ff[t] <= sa_dly_ff[t-1];
      end

      // tx, ty and the ex frame products
      ptx_ff <= 67'($signed({1'b0, sp_dly_ff[SP_DLY-1]})) * 67'(ca_dly_ff[CR_DLY-1]);
      pty_ff <= 67'($signed({1'b0, sp_dly_ff[SP_DLY-1]})) * 67'(sa_dly_ff[CR_DLY-1]);
      pex_ff <= 64'(q_ff[U_COSTH]) * 64'(q_ff[U_COSPH]);
      pey_ff <= 64'(q_ff[U_COSTH]) * 64'(q_ff[U_SINPH]);
      p1_cosph_ff <= q_ff[U_COSPH];
      p1_sinph_ff <= q_ff[U_SINPH];
      p1_sinth_ff <= q_ff[U_SINTH];

      geo_ff[0].tx <= tx_in;
      geo_ff[0].ty <= ty_in;
      geo_ff[0].exx <= 32'(pex_ff >>> 30);
      geo_ff[0].exy <= 32'(pey_ff >>> 30);
      geo_ff[0].sinth <= p1_sinth_ff;
      geo_ff[0].cosph <= p1_cosph_ff;
      geo_ff[0].sinph <= p1_sinph_ff;
      for (int g = 1; g < GEO_LEN; g++) begin
         geo_ff[g] <= geo_ff[g-1];
      end
      txx_ff <= txx_in[63:0];
      tyy_ff <= tyy_in[63:0];
      tz_seed_ff <= (tzrem_in > 66'sd0) ? tzrem_in[63:0] : 64'd0;

      // final rotation
      px0_ff <= 68'(tzs_in) * 68'(cf.x);
      px1_ff <= 68'(gf.tx) * 68'(gf.exx);
      px2_ff <= 68'(gf.ty) * 68'(gf.sinph);
      py0_ff <= 68'(tzs_in) * 68'(cf.y);
      py1_ff <= 68'(gf.tx) * 68'(gf.exy);
      py2_ff <= 68'(gf.ty) * 68'(gf.cosph);
      pz0_ff <= 68'(tzs_in) * 68'(cf.z);
      pz1_ff <= 68'(gf.tx) * 68'(exz_in);

      sx_ff <= px0_ff + px1_ff - px2_ff;
      sy_ff <= py0_ff + py1_ff + py2_ff;
      sz_ff <= pz0_ff + pz1_ff;

      if (cr_ff[T_F2].pass) begin
         rsp_word_ff.new_x <= cr_ff[T_F2].x;
         rsp_word_ff.new_y <= cr_ff[T_F2].y;
         rsp_word_ff.new_z <= cr_ff[T_F2].z;
         rsp_word_ff.passed_through <= 1'b1;
      end else begin
         rsp_word_ff.new_x <= sat_q30(sx_ff);
         rsp_word_ff.new_y <= sat_q30(sy_ff);
         rsp_word_ff.new_z <= sat_q30(sz_ff);
         rsp_word_ff.passed_through <= 1'b0;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word = rsp_word_ff;

`ifndef SYNTHESIS
   a_strobe_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, T_OUT + 1))
      else $error("result word without an accepted request");

   a_pass_matches_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.passed_through |->
         $past(req_word.cos_polar, T_OUT + 1) == ddr_pkg::ONE_Q30 &&
         $past(req_word.deflect_azimuth, T_OUT + 1) == 32'sd0 &&
         $past(req_word.dir_x, T_OUT + 1) == rsp_word.new_x)
      else $error("pass-through word does not match its request");

   a_rho_not_above_r: assert property (@(posedge clock) disable iff (reset)
      vld_ff[T_RT] |-> rho_sq_ff[SQRT_STEPS-1].res <= r_sq_ff[SQRT_STEPS-1].res &&
                       r_sq_ff[SQRT_STEPS-1].res[63:32] == 32'd0)
      else $error("square root stage out of range");

   // a zero divisor leaves a meaningless quotient that div_final replaces
   a_quotient_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[T_DV] |->
         (dv_ff[U_COSTH][DIV_STEPS].zero ||
          dv_ff[U_COSTH][DIV_STEPS].quo <= 31'h4000_0000) &&
         (dv_ff[U_COSPH][DIV_STEPS].zero ||
          dv_ff[U_COSPH][DIV_STEPS].quo <= 31'h4000_0000))
      else $error("divider quotient above one");
`endif

endmodule
